### sv/ahsfp_pkg.sv
// Shared types, constants and helpers for the ASCII hex sensor-frame parser.
// Used by ahsfp_line and ascii_hex_sensor_frame_parser_unit; no dependencies.

package ahsfp_pkg;

    // Frame geometry: hex characters after ':' up to and including the frame bytes
    localparam int SHORT_FRAME_CHARS = 47;
    localparam int LONG_FRAME_CHARS  = 51;
    localparam int NB_SHORT_INT = ((SHORT_FRAME_CHARS % 64) >= 1) ?
                                  ((SHORT_FRAME_CHARS % 64) - 1) / 2 : 0;
    localparam int NB_LONG_INT  = ((LONG_FRAME_CHARS % 64) >= 1) ?
                                  ((LONG_FRAME_CHARS % 64) - 1) / 2 : 0;
    localparam logic [4:0] NB_SHORT = 5'(NB_SHORT_INT);
    localparam logic [4:0] NB_LONG  = 5'(NB_LONG_INT);

    // Highest frame byte that is captured
    localparam int CAPT_BYTES = 24;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DATA   = 3'd1;
    localparam logic [2:0] ST_LRC_ERR   = 3'd2;
    localparam logic [2:0] ST_TYPE_ERR  = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;
    localparam logic [2:0] ST_NO_START  = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_MODE  = 3'd0;
    localparam logic [2:0] REG_EXPECTED_ID = 3'd1;
    localparam logic [2:0] REG_TYPE_A      = 3'd2;
    localparam logic [2:0] REG_TYPE_B      = 3'd3;
    localparam logic [2:0] REG_LQI_ALERT   = 3'd4;
    localparam logic [2:0] REG_BATT_ALERT  = 3'd5;

    localparam logic [7:0]  LQI_ALERT_RESET  = 8'd50;
    localparam logic [15:0] BATT_ALERT_RESET = 16'd2250;

    typedef struct packed {
        logic [1:0]  frame_mode;
        logic [7:0]  expected_msg_id;
        logic [7:0]  type_a;
        logic [7:0]  type_b;
        logic [7:0]  lqi_alert_level;
        logic [15:0] batt_alert_level;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  sensor_type;
        logic        type_index;
        logic [7:0]  link_quality;
        logic [31:0] node_address;
        logic [7:0]  sequence_res;
        logic [7:0]  repeat_count;
        logic [7:0]  switch_bits;
        logic        switch_on;
        logic        weak_signal;
        logic        battery_low;
        logic [55:0] analog_bytes;
    } result_t;

    // Hex digit to nibble; anything else decodes as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h37);
        end
        return n;
    endfunction

endpackage

### sv/ascii_hex_sensor_frame_parser_unit.sv
// Top level of the ASCII hex sensor-frame parser: input register, configuration
// registers, line state (ahsfp_line) and result register. Depends on ahsfp_pkg.
//
//   port group   direction  handshake            carries
//   s_*          in         s_valid / s_ready    one character and end-of-buffer flag
//   m_*          out        m_valid / m_ready    status and fields of one finished line
//   cfg_*        in         cfg_we               register index and write data
//
// One character per cycle is sustained unless a line end stalls. A character is held in the
// input register, is decoded into the line state, and a line end loads the result
// register, which drives m_valid; the input register lies between acceptance and m_valid.
// Characters that end no line keep flowing while a result waits; only a line end
// stalls in the input register until the result register frees.
// Synchronous active-low reset clears the line state and loads register defaults.

module ascii_hex_sensor_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_end_of_buffer,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_sensor_type,
    output logic        m_type_index,
    output logic [7:0]  m_link_quality,
    output logic [31:0] m_node_address,
    output logic [7:0]  m_sequence_res,
    output logic [7:0]  m_repeat_count,
    output logic [7:0]  m_switch_bits,
    output logic        m_switch_on,
    output logic        m_weak_signal,
    output logic        m_battery_low,
    output logic [55:0] m_analog_bytes,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ahsfp_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    logic [7:0] ch_reg;
    logic    last_reg;
    logic    out_valid_reg;
    result_t res_reg;

    logic    emit;
    logic    advance;
    result_t result;

    // Step the held item unless it ends a line and the result slot is busy
    assign advance = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ahsfp_line u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .ch      (ch_reg),
        .last    (last_reg),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg   <= s_ch;
            last_reg <= s_end_of_buffer;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            res_reg <= result;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_mode       <= 2'd0;
            cfg_reg.expected_msg_id  <= 8'd0;
            cfg_reg.type_a           <= 8'd0;
            cfg_reg.type_b           <= 8'd0;
            cfg_reg.lqi_alert_level  <= LQI_ALERT_RESET;
            cfg_reg.batt_alert_level <= BATT_ALERT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_MODE:  cfg_reg.frame_mode       <= cfg_wdata[1:0];
                REG_EXPECTED_ID: cfg_reg.expected_msg_id  <= cfg_wdata[7:0];
                REG_TYPE_A:      cfg_reg.type_a           <= cfg_wdata[7:0];
                REG_TYPE_B:      cfg_reg.type_b           <= cfg_wdata[7:0];
                REG_LQI_ALERT:   cfg_reg.lqi_alert_level  <= cfg_wdata[7:0];
                REG_BATT_ALERT:  cfg_reg.batt_alert_level <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = res_reg.status;
    assign m_sensor_type  = res_reg.sensor_type;
    assign m_type_index   = res_reg.type_index;
    assign m_link_quality = res_reg.link_quality;
    assign m_node_address = res_reg.node_address;
    assign m_sequence_res = res_reg.sequence_res;
    assign m_repeat_count = res_reg.repeat_count;
    assign m_switch_bits  = res_reg.switch_bits;
    assign m_switch_on    = res_reg.switch_on;
    assign m_weak_signal  = res_reg.weak_signal;
    assign m_battery_low  = res_reg.battery_low;
    assign m_analog_bytes = res_reg.analog_bytes;

endmodule

### sv/ahsfp_line.sv
// Line state of the sensor-frame parser: hex pair decode, LRC and field capture,
// plus the status and field logic for the result of a finished line.
// Depends on ahsfp_pkg.

module ahsfp_line (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              last,
    input  ahsfp_pkg::cfg_t   cfg,
    output logic              emit,
    output ahsfp_pkg::result_t result
);
    import ahsfp_pkg::*;

    logic        started_reg, started_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  hi_reg, hi_next;
    logic [7:0]  lrc_reg, lrc_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  byte_reg [1:CAPT_BYTES];
    logic [7:0]  byte_next [1:CAPT_BYTES];
    logic        pending_reg, pending_next;
    logic        lrc_bad_reg, lrc_bad_next;
    logic        nonempty_reg, nonempty_next;

    // Values after this character is taken, before any line end
    logic        started_t;
    logic [5:0]  pos_t;
    logic [3:0]  hi_t;
    logic [7:0]  lrc_t;
    logic [31:0] shift_t;
    logic [7:0]  byte_t [1:CAPT_BYTES];
    logic        pending_t;
    logic        lrc_bad_t;
    logic        nonempty_t;

    logic        term;
    logic        long_mode;
    logic [4:0]  nb;
    logic [3:0]  nib;
    logic [7:0]  val;
    logic [4:0]  bidx;
    logic [7:0]  want;
    logic [2:0]  status;
    logic        tidx;
    logic [15:0] batt;

    assign term      = (ch == CH_CR) || (ch == CH_LF) || (ch == CH_NUL);
    assign long_mode = cfg.frame_mode[1];
    assign nb        = long_mode ? NB_LONG : NB_SHORT;
    assign nib       = nibble_of(ch);
    assign val       = {hi_reg, nib};
    assign bidx      = pos_reg[5:1];
    assign want      = 8'(~lrc_reg + 8'd1);
    assign emit      = term || last;

    // Take one character into the line state
    always_comb begin
        started_t  = started_reg;
        pos_t      = pos_reg;
        hi_t       = hi_reg;
        lrc_t      = lrc_reg;
        shift_t    = shift_reg;
        pending_t  = pending_reg;
        lrc_bad_t  = lrc_bad_reg;
        nonempty_t = nonempty_reg;
        for (int k = 1; k <= CAPT_BYTES; k++) begin
            byte_t[k] = byte_reg[k];
        end
        if (!term) begin
            nonempty_t = 1'b1;
            if (!started_reg) begin
                if (ch == CH_COLON) begin
                    started_t = 1'b1;
                    pos_t     = 6'd0;
                    pending_t = 1'b1;
                    lrc_bad_t = 1'b0;
                end
            end else if (pending_reg) begin
                if (!pos_reg[0]) begin
                    hi_t  = nib;
                    pos_t = pos_reg + 6'd1;
                end else if (bidx < nb) begin
                    lrc_t = lrc_reg + val;
                    for (int k = 1; k <= CAPT_BYTES; k++) begin
                        if (bidx == 5'(k)) begin
                            byte_t[k] = val;
                        end
                    end
                    if (bidx >= 5'd5 && bidx <= 5'd8) begin
                        shift_t = {shift_reg[23:0], val};
                    end
                    pos_t = pos_reg + 6'd1;
                end else begin
                    pending_t = 1'b0;
                    lrc_bad_t = (want != val);
                end
            end
        end
    end

    // Status of the line, checks in priority order
    always_comb begin
        tidx = 1'b0;
        priority if (!nonempty_t) begin
            status = ST_NO_DATA;
        end else if (!started_t) begin
            status = ST_NO_START;
        end else if (pending_t) begin
            status = ST_SHORT;
        end else if (byte_t[1] != cfg.expected_msg_id) begin
            status = ST_NO_DATA;
        end else if (lrc_bad_t) begin
            status = ST_LRC_ERR;
        end else if (byte_t[2] == cfg.type_a) begin
            status = ST_OK;
        end else if (cfg.frame_mode != 2'd0 && byte_t[2] == cfg.type_b) begin
            status = ST_OK;
            tidx   = 1'b1;
        end else begin
            status = ST_TYPE_ERR;
        end
    end

    // Fields of the result; all zero on a failed line
    assign batt = {byte_t[13], byte_t[14]};

    always_comb begin
        result        = '0;
        result.status = status;
        if (status == ST_OK) begin
            result.sensor_type  = byte_t[2];
            result.type_index   = tidx;
            result.link_quality = byte_t[4];
            result.node_address = shift_t;
            result.sequence_res = byte_t[15];
            result.repeat_count = byte_t[17];
            result.switch_bits  = byte_t[16];
            result.switch_on    = (byte_t[16] != 8'd0);
            result.weak_signal  = (byte_t[4] < cfg.lqi_alert_level);
            result.battery_low  = (batt < cfg.batt_alert_level);
            result.analog_bytes = {long_mode ? byte_t[24] : 8'd0,
                                   long_mode ? byte_t[23] : 8'd0,
                                   byte_t[22], byte_t[21], byte_t[20],
                                   byte_t[19], byte_t[18]};
        end
    end

    // Advance on each step; clear the line after a result
    always_comb begin
        started_next  = started_reg;
        pos_next      = pos_reg;
        hi_next       = hi_reg;
        lrc_next      = lrc_reg;
        shift_next    = shift_reg;
        pending_next  = pending_reg;
        lrc_bad_next  = lrc_bad_reg;
        nonempty_next = nonempty_reg;
        for (int k = 1; k <= CAPT_BYTES; k++) begin
            byte_next[k] = byte_reg[k];
        end
        if (step) begin
            if (emit) begin
                started_next  = 1'b0;
                pos_next      = 6'd0;
                hi_next       = 4'd0;
                lrc_next      = 8'd0;
                shift_next    = 32'd0;
                pending_next  = 1'b0;
                lrc_bad_next  = 1'b0;
                nonempty_next = 1'b0;
                for (int k = 1; k <= CAPT_BYTES; k++) begin
                    byte_next[k] = 8'd0;
                end
            end else begin
                started_next  = started_t;
                pos_next      = pos_t;
                hi_next       = hi_t;
                lrc_next      = lrc_t;
                shift_next    = shift_t;
                pending_next  = pending_t;
                lrc_bad_next  = lrc_bad_t;
                nonempty_next = nonempty_t;
                for (int k = 1; k <= CAPT_BYTES; k++) begin
                    byte_next[k] = byte_t[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            pos_reg      <= 6'd0;
            hi_reg       <= 4'd0;
            lrc_reg      <= 8'd0;
            shift_reg    <= 32'd0;
            pending_reg  <= 1'b0;
            lrc_bad_reg  <= 1'b0;
            nonempty_reg <= 1'b0;
            for (int k = 1; k <= CAPT_BYTES; k++) begin
                byte_reg[k] <= 8'd0;
            end
        end else begin
            started_reg  <= started_next;
            pos_reg      <= pos_next;
            hi_reg       <= hi_next;
            lrc_reg      <= lrc_next;
            shift_reg    <= shift_next;
            pending_reg  <= pending_next;
            lrc_bad_reg  <= lrc_bad_next;
            nonempty_reg <= nonempty_next;
            for (int k = 1; k <= CAPT_BYTES; k++) begin
                byte_reg[k] <= byte_next[k];
            end
        end
    end

endmodule
